>>> rtl/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared property wrappers for the queue's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check that cond holds in the same cycle as trig
`define DEQ_ASSERT_SAME(name, clk, rst, trig, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Check that cond holds in the cycle after trig
`define DEQ_ASSERT_NEXT(name, clk, rst, trig, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request kinds, response status codes and fixed field widths.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int KIND_BITS   = 3;
   localparam int DATA_BITS   = 32;
   localparam int STATUS_BITS = 2;

   // Request kinds; code 7 is unused and answers ok without effect
   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_PEEK_FRONT = 3'd4,
      KIND_PEEK_BACK  = 3'd5,
      KIND_CLEAR      = 3'd6
   } kind_type;

   // Response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_VALUE = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

endpackage

>>> rtl/deq_req_if.sv
// ----------------------------------------------------------------------------
// Double-ended queue request channel
// Valid/ready channel carrying the request kind and the word to push.
// ----------------------------------------------------------------------------
interface deq_req_if;

   logic                           valid;
   logic                           ready;
   logic [deq_pkg::KIND_BITS-1:0]  kind;
   logic [deq_pkg::DATA_BITS-1:0]  push_value;

   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);

endinterface

>>> rtl/deq_rsp_if.sv
// ----------------------------------------------------------------------------
// Double-ended queue response channel
// Valid/ready channel carrying the status and the word read back.
// ----------------------------------------------------------------------------
interface deq_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [deq_pkg::STATUS_BITS-1:0] status;
   logic [deq_pkg::DATA_BITS-1:0]   read_value;

   modport source (output valid, output status, output read_value, input ready);
   modport sink   (input valid, input status, input read_value, output ready);

endinterface

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue: ring memory with front index and entry count
// A request passes through the read stage register, then the response register.
// A new request is taken only once the last has left the read stage and its response can move.
// Reset: synchronous reset empties the queue; ring memory is not cleared.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_chan,
   deq_rsp_if.source  rsp_chan
);

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS = IDX_BITS + 1;
   localparam int OUT_BITS = deq_pkg::DATA_BITS;

   localparam logic [SUM_BITS-1:0] DEPTH_SUM  = SUM_BITS'(DEPTH);
   localparam logic [IDX_BITS-1:0] LAST_SLOT  = IDX_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   // Fold a sum of index and offset (below twice the depth) back into the ring
   function automatic logic [IDX_BITS-1:0] wrap_slot(input logic [SUM_BITS-1:0] sum);
      logic [SUM_BITS-1:0] folded;
      folded = (sum >= DEPTH_SUM) ? (sum - DEPTH_SUM) : sum;
      return folded[IDX_BITS-1:0];
   endfunction

   // Ring storage and queue pointers
   logic [WORD_BITS-1:0] ring_store_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [IDX_BITS-1:0]  front_ff, front_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   // Read stage and response register
   logic                 s1_valid_ff;
   deq_pkg::status_type  s1_status_ff, s1_status_in;
   logic                 s1_read_ff, s1_read_in;
   logic                 rsp_valid_ff;
   deq_pkg::status_type  rsp_status_ff;
   logic [OUT_BITS-1:0]  rsp_value_ff;

   logic                 req_accept;
   logic                 rsp_taken;
   logic                 is_empty;
   logic                 is_full;
   logic                 is_push;
   logic [IDX_BITS-1:0]  prev_slot;
   logic [IDX_BITS-1:0]  next_slot;
   logic [IDX_BITS-1:0]  tail_slot;
   logic [IDX_BITS-1:0]  back_slot;
   logic                 mem_we;
   logic [IDX_BITS-1:0]  mem_waddr;
   logic                 mem_re;
   logic [IDX_BITS-1:0]  mem_raddr;

   // Handshakes: take a request only when its result can move straight on
   assign rsp_taken      = rsp_valid_ff && rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_value_ff;

   // Ring slot arithmetic
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == FULL_COUNT);
   assign prev_slot = (front_ff == '0) ? LAST_SLOT : (front_ff - IDX_BITS'(1));
   assign next_slot = wrap_slot({1'b0, front_ff} + SUM_BITS'(1));
   assign tail_slot = wrap_slot({1'b0, front_ff} + SUM_BITS'(count_ff));
   assign back_slot = wrap_slot({1'b0, front_ff} + SUM_BITS'(count_ff) - SUM_BITS'(1));
   assign is_push   = (req_chan.kind == deq_pkg::KIND_PUSH_FRONT) ||
                      (req_chan.kind == deq_pkg::KIND_PUSH_BACK);

   // Decode the request: pointer updates, memory access and status
   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      mem_we       = 1'b0;
      mem_waddr    = tail_slot;
      mem_re       = 1'b0;
      mem_raddr    = front_ff;
      s1_status_in = deq_pkg::STATUS_OK;
      s1_read_in   = 1'b0;
      case (req_chan.kind)
         deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
            if (is_full) begin
               s1_status_in = deq_pkg::STATUS_FULL;
            end else begin
               mem_we   = req_accept;
               count_in = count_ff + CNT_BITS'(1);
               if (req_chan.kind == deq_pkg::KIND_PUSH_FRONT) begin
                  mem_waddr = prev_slot;
                  front_in  = prev_slot;
               end
            end
         end
         deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_PEEK_FRONT: begin
            if (is_empty) begin
               s1_status_in = deq_pkg::STATUS_EMPTY;
            end else begin
               s1_status_in = deq_pkg::STATUS_VALUE;
               s1_read_in   = 1'b1;
               mem_re       = req_accept;
               if (req_chan.kind == deq_pkg::KIND_POP_FRONT) begin
                  front_in = next_slot;
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
         end
         deq_pkg::KIND_POP_BACK, deq_pkg::KIND_PEEK_BACK: begin
            if (is_empty) begin
               s1_status_in = deq_pkg::STATUS_EMPTY;
            end else begin
               s1_status_in = deq_pkg::STATUS_VALUE;
               s1_read_in   = 1'b1;
               mem_re       = req_accept;
               mem_raddr    = back_slot;
               if (req_chan.kind == deq_pkg::KIND_POP_BACK) begin
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
         end
         deq_pkg::KIND_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Ring memory: one write and one registered read per cycle; no request is
   // taken while the last is in the read stage, so a read never meets a write to its slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_store_ff[mem_waddr] <= WORD_BITS'(req_chan.push_value);
      end
      if (mem_re) begin
         rd_data_ff <= ring_store_ff[mem_raddr];
      end
   end

   // Advance pointers on each request transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (req_accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // Hold the request's status while the memory read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_status_ff <= s1_status_in;
         s1_read_ff   <= s1_read_in;
      end
   end

   // Load the response register; drop it once the transaction completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_valid_ff) begin
         rsp_status_ff <= s1_status_ff;
         rsp_value_ff  <= s1_read_ff ? OUT_BITS'(rd_data_ff) : '0;
      end
   end

   // Checks
   `DEQ_ASSERT_SAME(count_in_range, clock, reset, 1'b1, count_ff <= FULL_COUNT, "entry count above depth")
   `DEQ_ASSERT_SAME(front_in_range, clock, reset, 1'b1, front_ff <= LAST_SLOT, "front index outside ring")
   `DEQ_ASSERT_NEXT(stage_drains, clock, reset, s1_valid_ff, rsp_valid_ff, "read stage result not registered")
   `DEQ_ASSERT_NEXT(full_push_holds, clock, reset, req_accept && is_push && is_full, $stable(count_ff) && $stable(front_ff), "refused push changed the queue")

endmodule

>>> dv/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, peek and clear requests with random gaps on both
// channels, predicts each response from a shadow ring and compares the
// status and read word of every response in order.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

   localparam int DEPTH        = 16;
   localparam int WORD_BITS    = 32;
   localparam int STALL_LIMIT  = 1000;
   localparam int CALM_TAIL    = 150;
   localparam int RANDOM_ITEMS = 1375;

   // Code 7 has no kind in the package; the queue answers ok and does nothing
   localparam logic [deq_pkg::KIND_BITS-1:0] KIND_UNUSED = 3'd7;

   typedef struct packed {
      logic [deq_pkg::KIND_BITS-1:0] kind;
      logic [deq_pkg::DATA_BITS-1:0] push_value;
   } request_type;

   typedef struct packed {
      deq_pkg::status_type           status;
      logic [deq_pkg::DATA_BITS-1:0] read_value;
   } response_type;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   logic clock = 1'b0;
   logic reset;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the queue contents
   logic [WORD_BITS-1:0] ring_words [DEPTH];
   int unsigned          front_slot;
   int unsigned          held_count;

   request_type  pending_requests [$];
   response_type expected_responses [$];

   int  planned_requests  = 0;
   int  accepted_requests = 0;
   int  mismatches        = 0;
   int  quiet_cycles      = 0;
   int  send_gap          = 0;
   int  stall_left        = 0;
   bit  stimulus_complete = 1'b0;
   bit  req_taken         = 1'b0;

   always #5 clock = ~clock;

   // Work out the response of one request and advance the shadow queue
   function automatic response_type predict_response(input request_type item);
      response_type rsp;
      int unsigned  back_slot;
      rsp.status     = deq_pkg::STATUS_OK;
      rsp.read_value = '0;
      case (item.kind)
         deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
            if (held_count == DEPTH) begin
               rsp.status = deq_pkg::STATUS_FULL;
            end else if (item.kind == deq_pkg::KIND_PUSH_FRONT) begin
               front_slot = (front_slot == 0) ? DEPTH - 1 : front_slot - 1;
               ring_words[front_slot] = item.push_value;
               held_count++;
            end else begin
               ring_words[(front_slot + held_count) % DEPTH] = item.push_value;
               held_count++;
            end
         end
         deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK,
         deq_pkg::KIND_PEEK_FRONT, deq_pkg::KIND_PEEK_BACK: begin
            if (held_count == 0) begin
               rsp.status = deq_pkg::STATUS_EMPTY;
            end else begin
               rsp.status = deq_pkg::STATUS_VALUE;
               back_slot  = (front_slot + held_count - 1) % DEPTH;
               if (item.kind == deq_pkg::KIND_POP_FRONT ||
                   item.kind == deq_pkg::KIND_PEEK_FRONT) begin
                  rsp.read_value = ring_words[front_slot];
               end else begin
                  rsp.read_value = ring_words[back_slot];
               end
               if (item.kind == deq_pkg::KIND_POP_FRONT) begin
                  front_slot = (front_slot + 1) % DEPTH;
                  held_count--;
               end else if (item.kind == deq_pkg::KIND_POP_BACK) begin
                  held_count--;
               end
            end
         end
         deq_pkg::KIND_CLEAR: begin
            front_slot = 0;
            held_count = 0;
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   // Idling stops in regular windows and over the last stretch of the run
   function automatic bit no_idling();
      return (stimulus_complete && accepted_requests >= planned_requests - CALM_TAIL) ||
             ((accepted_requests / 64) % 4 == 3);
   endfunction

   function automatic logic [deq_pkg::DATA_BITS-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Corner words for the directed fill
   function automatic logic [deq_pkg::DATA_BITS-1:0] corner_word(input int idx);
      case (idx)
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'hAAAA_AAAA;
         3:       return 32'h5555_5555;
         4:       return 32'h8000_0000;
         5:       return 32'h0000_0001;
         6:       return 32'h7FFF_FFFF;
         default: return 32'hFFFF_FFFE;
      endcase
   endfunction

   task automatic add_request(input logic [deq_pkg::KIND_BITS-1:0] kind,
                              input logic [deq_pkg::DATA_BITS-1:0] word);
      request_type item;
      item.kind       = kind;
      item.push_value = word;
      pending_requests.push_back(item);
      planned_requests++;
   endtask

   // Random traffic in runs biased towards filling, draining or neither
   task automatic add_random_requests(input int wanted);
      int                            made;
      int                            run_left;
      int                            push_pct;
      int                            pick;
      mix_type                       mix;
      logic [deq_pkg::KIND_BITS-1:0] kind;
      made     = 0;
      run_left = 0;
      mix      = MIX_EVEN;
      while (made < wanted) begin
         if (run_left == 0) begin
            case ($urandom_range(0, 2))
               0:       mix = MIX_FILL;
               1:       mix = MIX_DRAIN;
               default: mix = MIX_EVEN;
            endcase
            run_left = $urandom_range(8, 40);
         end
         run_left--;
         push_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
         pick     = $urandom_range(0, 99);
         if (pick < 2) begin
            kind = deq_pkg::KIND_CLEAR;
         end else if (pick < 3) begin
            kind = KIND_UNUSED;
         end else if ($urandom_range(0, 99) < push_pct) begin
            kind = $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT;
         end else begin
            case ($urandom_range(0, 3))
               0:       kind = deq_pkg::KIND_POP_FRONT;
               1:       kind = deq_pkg::KIND_POP_BACK;
               2:       kind = deq_pkg::KIND_PEEK_FRONT;
               default: kind = deq_pkg::KIND_PEEK_BACK;
            endcase
         end
         add_request(kind, random_word());
         if (kind != KIND_UNUSED) begin
            made++;
         end
      end
   endtask

   // Drive requests at the falling edge, holding each until it is taken
   always @(negedge clock) begin : drive_requests
      request_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_taken) begin
         // hold the offered transaction
      end else if (send_gap > 0) begin
         req_bus.valid <= 1'b0;
         send_gap      <= send_gap - 1;
      end else if (pending_requests.size() != 0 && !no_idling() &&
                   $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         send_gap      <= $urandom_range(0, 9);
      end else if (pending_requests.size() != 0) begin
         next_item          = pending_requests.pop_front();
         req_bus.valid      <= 1'b1;
         req_bus.kind       <= next_item.kind;
         req_bus.push_value <= next_item.push_value;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Stall the response channel in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (!no_idling() && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 9);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Predict on each request transaction, check each response transaction
   always @(posedge clock) begin : track_transactions
      request_type  taken;
      response_type want;
      if (reset) begin
         front_slot   = 0;
         held_count   = 0;
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.kind       = req_bus.kind;
            taken.push_value = req_bus.push_value;
            expected_responses.push_back(predict_response(taken));
            accepted_requests++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding: status %0d, read_value %h",
                      rsp_bus.status, rsp_bus.read_value);
               mismatches++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                  mismatches++;
               end
               if (rsp_bus.read_value !== want.read_value) begin
                  $error("read_value: expected %h, actual %h",
                         want.read_value, rsp_bus.read_value);
                  mismatches++;
               end
            end
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("[double_ended_queue] ERROR");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.kind       = deq_pkg::KIND_PUSH_FRONT;
      req_bus.push_value = '0;
      rsp_bus.ready      = 1'b0;

      // Directed: every read kind on an empty queue and the unused code
      add_request(deq_pkg::KIND_POP_FRONT, 32'h1234_5678);
      add_request(deq_pkg::KIND_POP_BACK, '1);
      add_request(deq_pkg::KIND_PEEK_FRONT, '0);
      add_request(deq_pkg::KIND_PEEK_BACK, '0);
      add_request(KIND_UNUSED, 32'hDEAD_BEEF);
      // fill from both ends, refuse both pushes when full, pop each end and clear
      for (int i = 0; i < DEPTH; i++) begin
         add_request((i % 2 == 0) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_BACK,
                     (i < 8) ? corner_word(i) : random_word());
      end
      add_request(deq_pkg::KIND_PUSH_FRONT, 32'hCAFE_0001);
      add_request(deq_pkg::KIND_PUSH_BACK, 32'hCAFE_0002);
      add_request(deq_pkg::KIND_POP_FRONT, '0);
      add_request(deq_pkg::KIND_POP_BACK, '0);
      add_request(deq_pkg::KIND_CLEAR, '1);

      // First half of the random traffic
      add_random_requests(RANDOM_ITEMS / 2);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hold the sender until every response is back
      while (pending_requests.size() != 0 || req_bus.valid ||
             expected_responses.size() != 0) @(negedge clock);

      add_random_requests(RANDOM_ITEMS - RANDOM_ITEMS / 2);
      stimulus_complete = 1'b1;

      while (pending_requests.size() != 0 || req_bus.valid ||
             expected_responses.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && expected_responses.size() == 0) begin
         $display("[double_ended_queue] OK");
      end else begin
         $display("[double_ended_queue] ERROR");
      end
      $finish;
   end

endmodule
